// File: design/bounded_list_insert_delete_defines.svh
// ----------------------------------------------------------------------------
// bounded_list_insert_delete_defines.svh
// Assertion macros shared by the list block. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_INSERT_DELETE_DEFINES_SVH
`define BOUNDED_LIST_INSERT_DELETE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, switched off while reset is high
`define BLID_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also during reset
`define BLID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BLID_ASSERT(lbl, clk, rst, prop, msg)
`define BLID_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: design/blid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blid_pkg
// Types and constants for the bounded list block and its storage cells.
// ----------------------------------------------------------------------------
package blid_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      CMD_INSERT   = 3'd0,
      CMD_REM_HEAD = 3'd1,
      CMD_REM_TAIL = 3'd2,
      CMD_REM_VAL  = 3'd3,
      CMD_DUMP     = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_NOTFOUND = 2'd3
   } status_type;

   // What every cell does with its entry this cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHR,     // take the left neighbour (insert at head)
      CELL_SHL,     // take the right neighbour (remove head)
      CELL_CLOSE,   // take the right neighbour from the matching cell onwards
      CELL_ROT      // rotate towards the head, tail takes the old head
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        occ;       // this cell holds a live entry
      logic        occ_next;  // the cell to the right holds a live entry
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

endpackage

// File: design/blid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blid_cell
// One list entry: holds a value, compares it with the search key and moves
// values to and from its neighbours.
// ----------------------------------------------------------------------------
module blid_cell (
   input  logic                         clock,
   input  blid_pkg::cell_ctrl_type      ctrl,
   input  logic [blid_pkg::DATA_W-1:0]  left_value,
   input  logic [blid_pkg::DATA_W-1:0]  right_value,
   input  logic [blid_pkg::DATA_W-1:0]  head_value,
   input  logic [blid_pkg::DATA_W-1:0]  key,
   input  logic                         hit_in,
   output logic [blid_pkg::DATA_W-1:0]  value,
   output logic                         hit_out,
   output logic [blid_pkg::DATA_W-1:0]  tail_value
);

   logic [blid_pkg::DATA_W-1:0] value_ff;
   logic [blid_pkg::DATA_W-1:0] value_in;
   logic                        match;

   assign match      = ctrl.occ & (value_ff == key);
   assign hit_out    = hit_in | match;
   assign value      = value_ff;
   assign tail_value = (ctrl.occ & ~ctrl.occ_next) ? value_ff : '0;

   always_comb begin
      value_in = value_ff;
      unique case (ctrl.op)
         blid_pkg::CELL_HOLD:  value_in = value_ff;
         blid_pkg::CELL_SHR:   value_in = left_value;
         blid_pkg::CELL_SHL:   value_in = right_value;
         blid_pkg::CELL_CLOSE: value_in = hit_out ? right_value : value_ff;
         blid_pkg::CELL_ROT: begin
            if (ctrl.occ_next) begin
               value_in = right_value;
            end else if (ctrl.occ) begin
               value_in = head_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// File: design/bounded_list_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_insert_delete
// Bounded list of signed 32-bit values in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries a command and a value; rsp_* returns status, removed or
//   dumped value, entry count after the command and a last marker. A
//   transfer happens when valid is high and stall is low.
//   Insert, remove head, remove tail and remove by value act on the cell row
//   at once: every cell compares and shifts in parallel. The result sits in
//   the output register in the cycle after the request transfer, and a new
//   request is taken in every cycle while the result side keeps up.
//   Dump streams count results (one if the list is empty) by rotating the
//   cell row one place per cycle while the result side keeps up; the head
//   cell feeds the output register. Requests are held off during that,
//   from the transfer until the last entry is in the output register.
//   Commands 5 to 7 are taken and give no result.
//   Reset empties the list; entry contents need no clearing.
//   While a result waits and rsp_stall is high, it holds and req_stall
//   rises, so no request is taken until the waiting result is transferred.
// ----------------------------------------------------------------------------
`include "bounded_list_insert_delete_defines.svh"

module bounded_list_insert_delete #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_cmd,
   input  logic signed [blid_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic signed [blid_pkg::DATA_W-1:0] rsp_item_value,
   output logic [$clog2(DEPTH+1)-1:0]        rsp_entry_count,
   output logic                              rsp_last
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int DW = blid_pkg::DATA_W;

   blid_pkg::state_type     state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           dump_left_ff, dump_left_in;
   blid_pkg::cell_op_type   op;

   logic                    rsp_valid_ff;
   blid_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [DW-1:0]           rsp_item_value_ff, rsp_item_value_in;
   logic [CW-1:0]           rsp_entry_count_ff;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    load_rsp;

   logic                    out_free;
   logic                    accept;
   logic                    empty;
   logic                    full;
   logic                    found;

   logic [DW-1:0]           cell_value [DEPTH];
   logic [DW-1:0]           cell_tail  [DEPTH];
   logic                    cell_hit   [DEPTH];
   logic [DW-1:0]           tail_val;
   logic [DW-1:0]           key;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = (state_ff != blid_pkg::ST_IDLE) | ~out_free;
   assign accept    = req_valid & ~req_stall;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(DEPTH));
   assign key       = $unsigned(req_value);
   assign found     = cell_hit[DEPTH-1];

   // Cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      blid_pkg::cell_ctrl_type ctrl;
      logic [DW-1:0]           left_v;
      logic [DW-1:0]           right_v;
      logic                    hit_prev;

      assign ctrl.op       = op;
      assign ctrl.occ      = (count_ff > CW'(i));
      assign ctrl.occ_next = (count_ff > CW'(i + 1));

      if (i == 0) begin : g_head
         assign left_v   = key;
         assign hit_prev = 1'b0;
      end else begin : g_body
         assign left_v   = cell_value[i-1];
         assign hit_prev = cell_hit[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_v = '0;
      end else begin : g_inner
         assign right_v = cell_value[i+1];
      end

      blid_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .left_value  (left_v),
         .right_value (right_v),
         .head_value  (cell_value[0]),
         .key         (key),
         .hit_in      (hit_prev),
         .value       (cell_value[i]),
         .hit_out     (cell_hit[i]),
         .tail_value  (cell_tail[i])
      );
   end

   // Only the tail cell drives a non-zero value here
   always_comb begin
      tail_val = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_val = tail_val | cell_tail[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blid_pkg::ST_IDLE;
         count_ff     <= '0;
         dump_left_ff <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      dump_left_in      = dump_left_ff;
      op                = blid_pkg::CELL_HOLD;
      load_rsp          = 1'b0;
      rsp_status_in     = blid_pkg::STATUS_OK;
      rsp_item_value_in = '0;
      rsp_last_in       = 1'b1;

      unique case (state_ff)
         blid_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (blid_pkg::cmd_type'(req_cmd))
                  blid_pkg::CMD_INSERT: begin
                     load_rsp = 1'b1;
                     if (full) begin
                        rsp_status_in = blid_pkg::STATUS_FULL;
                     end else begin
                        op       = blid_pkg::CELL_SHR;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  blid_pkg::CMD_REM_HEAD: begin
                     load_rsp = 1'b1;
                     if (empty) begin
                        rsp_status_in = blid_pkg::STATUS_EMPTY;
                     end else begin
                        op                = blid_pkg::CELL_SHL;
                        count_in          = count_ff - CW'(1);
                        rsp_item_value_in = cell_value[0];
                     end
                  end
                  blid_pkg::CMD_REM_TAIL: begin
                     load_rsp = 1'b1;
                     if (empty) begin
                        rsp_status_in = blid_pkg::STATUS_EMPTY;
                     end else begin
                        count_in          = count_ff - CW'(1);
                        rsp_item_value_in = tail_val;
                     end
                  end
                  blid_pkg::CMD_REM_VAL: begin
                     load_rsp = 1'b1;
                     if (empty) begin
                        rsp_status_in = blid_pkg::STATUS_EMPTY;
                     end else if (found) begin
                        op                = blid_pkg::CELL_CLOSE;
                        count_in          = count_ff - CW'(1);
                        rsp_item_value_in = key;
                     end else begin
                        rsp_status_in = blid_pkg::STATUS_NOTFOUND;
                     end
                  end
                  blid_pkg::CMD_DUMP: begin
                     if (empty) begin
                        load_rsp      = 1'b1;
                        rsp_status_in = blid_pkg::STATUS_EMPTY;
                     end else begin
                        state_in     = blid_pkg::ST_DUMP;
                        dump_left_in = count_ff;
                     end
                  end
                  default: begin
                     // undefined command: drop it
                  end
               endcase
            end
         end
         blid_pkg::ST_DUMP: begin
            if (out_free) begin
               load_rsp          = 1'b1;
               op                = blid_pkg::CELL_ROT;
               rsp_item_value_in = cell_value[0];
               rsp_last_in       = (dump_left_ff == CW'(1));
               dump_left_in      = dump_left_ff - CW'(1);
               if (dump_left_ff == CW'(1)) begin
                  state_in = blid_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = blid_pkg::ST_IDLE;
      endcase
   end

   // Output register: load a new result, or drop the old one once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff      <= rsp_status_in;
         rsp_item_value_ff  <= rsp_item_value_in;
         rsp_entry_count_ff <= count_in;
         rsp_last_ff        <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_item_value  = $signed(rsp_item_value_ff);
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_last        = rsp_last_ff;

   `BLID_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "count beyond depth")
   `BLID_ASSERT(a_dump_blocks, clock, reset,
      state_ff == blid_pkg::ST_DUMP |-> req_stall, "request taken during dump")
   `BLID_ASSERT(a_dump_keeps_count, clock, reset,
      state_ff == blid_pkg::ST_DUMP |=> count_ff == $past(count_ff), "dump changed count")
   `BLID_ASSERT(a_insert_grows, clock, reset,
      accept && req_cmd == blid_pkg::CMD_INSERT && !full
         |=> count_ff == $past(count_ff) + CW'(1),
      "insert did not add an entry")

endmodule
